[rtl/scpc_pkg.sv]
// Shared constants, types and constant tables of the stick-to-PWM conditioner.
package scpc_pkg;

    // Converter and PWM scales.
    localparam int ADC_MAX   = 1023;
    localparam int PWM_TOP   = 255;
    localparam int RAW_W     = 10;
    localparam int PWM_W     = 8;
    localparam int NUM_CH    = 4;
    localparam int CH_W      = 2;

    // Expo curve: the stick is mapped to -EXPO_HALF..EXPO_HALF and cubed.
    localparam int EXPO_HALF  = 100;
    localparam int CUBE_SPAN  = EXPO_HALF * EXPO_HALF * EXPO_HALF;
    localparam int CUBE_RANGE = 2 * CUBE_SPAN;

    // Stick ranges of the four channels.
    localparam int THR_LO = 1;
    localparam int THR_HI = 1020;
    localparam int YAW_LO = 4;
    localparam int YAW_HI = 1018;
    localparam int PIT_LO = 1;
    localparam int PIT_HI = 1020;
    localparam int ROL_LO = 4;
    localparam int ROL_HI = 1018;

    // Datapath widths.
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 23;
    localparam int PROD_W  = 44;
    localparam int DIVD_W  = 31;
    localparam int QUO_W   = 11;
    localparam int SHIFT_W = 5;

    // Reciprocal division: q = (a * RECIP) >> SHIFT, then one correction step.
    // Every SHIFT is chosen so that 2**SHIFT exceeds the largest dividend.
    localparam int SHIFT_FIVE   = 13;
    localparam int SHIFT_ADC    = 18;
    localparam int SHIFT_CUBE   = 31;
    localparam int SHIFT_SPAN   = 18;
    localparam int DIV_FIVE     = 5;
    localparam int DIV_WIDE     = THR_HI - THR_LO;
    localparam int DIV_NARROW   = YAW_HI - YAW_LO;
    localparam longint RECIP_FIVE   = (64'd1 << SHIFT_FIVE) / DIV_FIVE;
    localparam longint RECIP_ADC    = (64'd1 << SHIFT_ADC) / ADC_MAX;
    localparam longint RECIP_CUBE   = (64'd1 << SHIFT_CUBE) / CUBE_RANGE;
    localparam longint RECIP_WIDE   = (64'd1 << SHIFT_SPAN) / DIV_WIDE;
    localparam longint RECIP_NARROW = (64'd1 << SHIFT_SPAN) / DIV_NARROW;

    // Configuration port.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [APB_AW-3:0] CFG_EXPO_IDX = '0;

    typedef enum logic [2:0] {
        DIV_BY_FIVE,
        DIV_BY_ADC,
        DIV_BY_CUBE,
        DIV_BY_WIDE,
        DIV_BY_NARROW
    } t_div_kind;

    typedef struct packed {
        logic [MUL_B_W-1:0] divisor;
        logic [QUO_W-1:0]   recip;
        logic [SHIFT_W-1:0] shift;
    } t_div_const;

    typedef struct packed {
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } t_mul_req;

    function automatic t_div_const div_const(input t_div_kind kind);
        t_div_const dc;
        unique case (kind)
            DIV_BY_FIVE: begin
                dc = '{MUL_B_W'(DIV_FIVE), QUO_W'(RECIP_FIVE), SHIFT_W'(SHIFT_FIVE)};
            end
            DIV_BY_ADC: begin
                dc = '{MUL_B_W'(ADC_MAX), QUO_W'(RECIP_ADC), SHIFT_W'(SHIFT_ADC)};
            end
            DIV_BY_CUBE: begin
                dc = '{MUL_B_W'(CUBE_RANGE), QUO_W'(RECIP_CUBE), SHIFT_W'(SHIFT_CUBE)};
            end
            DIV_BY_WIDE: begin
                dc = '{MUL_B_W'(DIV_WIDE), QUO_W'(RECIP_WIDE), SHIFT_W'(SHIFT_SPAN)};
            end
            DIV_BY_NARROW: begin
                dc = '{MUL_B_W'(DIV_NARROW), QUO_W'(RECIP_NARROW), SHIFT_W'(SHIFT_SPAN)};
            end
            default: begin
                dc = '{MUL_B_W'(DIV_FIVE), QUO_W'(RECIP_FIVE), SHIFT_W'(SHIFT_FIVE)};
            end
        endcase
        return dc;
    endfunction

    // Lower end of each channel's stick range: throttle, yaw, pitch, roll.
    function automatic logic [RAW_W-1:0] chan_lo(input logic [CH_W-1:0] ch);
        logic [RAW_W-1:0] lo;
        unique case (ch)
            2'd0:    lo = RAW_W'(THR_LO);
            2'd1:    lo = RAW_W'(YAW_LO);
            2'd2:    lo = RAW_W'(PIT_LO);
            default: lo = RAW_W'(ROL_LO);
        endcase
        return lo;
    endfunction

    // Divisor of each channel's stick span.
    function automatic t_div_kind chan_span(input logic [CH_W-1:0] ch);
        t_div_kind kind;
        unique case (ch)
            2'd0:    kind = DIV_BY_WIDE;
            2'd1:    kind = DIV_BY_NARROW;
            2'd2:    kind = DIV_BY_WIDE;
            default: kind = DIV_BY_NARROW;
        endcase
        return kind;
    endfunction

endpackage

[rtl/scpc_ifs.sv]
// Valid/ready channel interfaces for stick samples and PWM words.
interface scpc_stick_if;
    logic                          valid;
    logic                          ready;
    logic [scpc_pkg::RAW_W-1:0]    raw_throttle;
    logic [scpc_pkg::RAW_W-1:0]    raw_yaw;
    logic [scpc_pkg::RAW_W-1:0]    raw_pitch;
    logic [scpc_pkg::RAW_W-1:0]    raw_roll;

    modport source (output valid, raw_throttle, raw_yaw, raw_pitch, raw_roll, input ready);
    modport sink (input valid, raw_throttle, raw_yaw, raw_pitch, raw_roll, output ready);
endinterface

interface scpc_pwm_if;
    logic                          valid;
    logic                          ready;
    logic [scpc_pkg::PWM_W-1:0]    throttle_pwm;
    logic [scpc_pkg::PWM_W-1:0]    yaw_pwm;
    logic [scpc_pkg::PWM_W-1:0]    pitch_pwm;
    logic [scpc_pkg::PWM_W-1:0]    roll_pwm;

    modport source (output valid, throttle_pwm, yaw_pwm, pitch_pwm, roll_pwm, input ready);
    modport sink (input valid, throttle_pwm, yaw_pwm, pitch_pwm, roll_pwm, output ready);
endinterface

[rtl/scpc_mul.sv]
// Shared signed multiplier with a registered product.
module scpc_mul (
    input  logic                                   i_clk,
    input  scpc_pkg::t_mul_req                     i_req,
    output logic signed [scpc_pkg::PROD_W-1:0]     o_prod
);
    import scpc_pkg::*;

    logic signed [MUL_A_W+MUL_B_W-1:0] w_full;
    logic signed [PROD_W-1:0]          r_prod;

    assign w_full = $signed(i_req.a) * $signed(i_req.b);

    always_ff @(posedge i_clk) begin
        r_prod <= w_full[PROD_W-1:0];
    end

    assign o_prod = r_prod;

endmodule

[rtl/scpc_cfg.sv]
// APB-style configuration register block holding the expo enable bit.
module scpc_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [scpc_pkg::APB_AW-1:0]   paddr,
    input  logic [scpc_pkg::APB_DW-1:0]   pwdata,
    output logic [scpc_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output logic                          o_expo_en
);
    import scpc_pkg::*;

    logic [APB_AW-3:0] w_idx;
    logic              w_wr;
    logic              r_expo;

    assign w_idx  = paddr[APB_AW-1:2];
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expo <= 1'b1;
        end else if (w_wr && (w_idx == CFG_EXPO_IDX)) begin
            r_expo <= pwdata[0];
        end
    end

    // Addresses beyond the register list read as zero.
    assign prdata    = (w_idx == CFG_EXPO_IDX) ? {{(APB_DW-1){1'b0}}, r_expo} : '0;
    assign o_expo_en = r_expo;

endmodule

[rtl/stick_to_pwm_conditioner.sv]
// Top level of the stick-to-PWM conditioner: sequencer, datapath and channels.
//
// Each word on i_stick carries one sample of throttle, yaw, pitch and roll. The block
// low-pass filters throttle (new = floor((4*old + raw)/5)), optionally bends yaw, pitch
// and roll through a cubic expo curve, maps all four onto 0..255 over their stick
// ranges with clamping, and delivers one word on o_pwm per input word.
// All multiplications and divisions run through one shared multiplier. A division by
// a constant runs as a reciprocal multiply, a back-multiply, and a single
// compare-and-correct step. A small sequencer walks the channels one after another.
// i_stick.ready is high only while the sequencer is idle, so a new word is accepted
// only after the previous one has been handed to the output register. A channel
// whose value falls below its stick range skips its last division.
// The result sits in an output register: the next word is accepted while it waits,
// and only the hand-over of the following result waits for o_pwm.ready.
// Reset clears the filtered throttle to zero, sets expo on, and empties the output.
// The expo bit lives at byte address 0 of the APB-style port; the user must write it
// only while the block is idle, as the block itself does not enforce this.
module stick_to_pwm_conditioner (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    scpc_stick_if.sink                    i_stick,
    scpc_pwm_if.source                    o_pwm,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [scpc_pkg::APB_AW-1:0]   paddr,
    input  logic [scpc_pkg::APB_DW-1:0]   pwdata,
    output logic [scpc_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import scpc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CH_START,
        S_CUBE_SQ,
        S_CUBE_CU,
        S_CUBE_SCALE,
        S_PWM_START,
        S_DIV_EST,
        S_DIV_BACK,
        S_DIV_FIX,
        S_OUT
    } t_state;

    // What the sequencer does with a finished quotient.
    typedef enum logic [1:0] {
        RET_THR,
        RET_V,
        RET_CURVE,
        RET_PWM
    } t_ret;

    t_state                   r_state;
    t_ret                     r_ret;
    t_div_kind                r_kind;
    logic                     r_use_p;
    logic [CH_W-1:0]          r_ch;
    logic                     r_out_valid;
    logic [RAW_W-1:0]         r_raw [NUM_CH];
    logic [RAW_W-1:0]         r_smooth;
    logic [DIVD_W-1:0]        r_div_a;
    logic [QUO_W-1:0]         r_q;
    logic signed [7:0]        r_v;
    logic [RAW_W-1:0]         r_x;
    logic [PWM_W-1:0]         r_pwm [NUM_CH];
    logic [PWM_W-1:0]         r_out [NUM_CH];

    logic                     w_expo;
    logic signed [PROD_W-1:0] w_prod;
    t_mul_req                 w_req;
    t_div_const               w_dc;
    logic [DIVD_W-1:0]        w_divd;
    logic [PROD_W-1:0]        w_shifted;
    logic [QUO_W-1:0]         w_est;
    logic [31:0]              w_rem;
    logic [QUO_W-1:0]         w_q_fix;
    logic signed [QUO_W:0]    w_v_next;
    logic [PWM_W-1:0]         w_pwm_clamp;
    logic [RAW_W-1:0]         w_lo;
    logic [RAW_W-1:0]         w_x_off;
    logic [31:0]              w_cube_off;
    logic                     w_last;
    logic                     w_accept;

    scpc_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_expo_en (w_expo)
    );

    scpc_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (w_req),
        .o_prod (w_prod)
    );

    assign i_stick.ready = (r_state == S_IDLE);
    assign w_accept      = i_stick.valid && i_stick.ready;

    // Division datapath. The estimate is at most one below the true quotient.
    assign w_dc        = div_const(r_kind);
    assign w_divd      = r_use_p ? w_prod[DIVD_W-1:0] : r_div_a;
    assign w_shifted   = w_prod >> w_dc.shift;
    assign w_est       = w_shifted[QUO_W-1:0];
    assign w_rem       = {1'b0, r_div_a} - w_prod[31:0];
    assign w_q_fix     = r_q + QUO_W'(w_rem >= 32'(w_dc.divisor));
    assign w_v_next    = $signed({1'b0, w_q_fix}) - (QUO_W+1)'(EXPO_HALF);
    assign w_pwm_clamp = (w_q_fix > QUO_W'(PWM_TOP)) ? PWM_W'(PWM_TOP) : w_q_fix[PWM_W-1:0];

    assign w_lo        = chan_lo(r_ch);
    assign w_x_off     = r_x - w_lo;
    assign w_cube_off  = w_prod[31:0] + 32'(CUBE_SPAN);
    assign w_last      = (r_ch == CH_W'(NUM_CH - 1));

    // Operand selection for the shared multiplier.
    always_comb begin
        w_req = '0;
        unique case (r_state)
            S_CH_START: begin
                w_req.a = MUL_A_W'(r_raw[r_ch]);
                w_req.b = MUL_B_W'(2 * EXPO_HALF);
            end
            S_CUBE_SQ: begin
                w_req.a = MUL_A_W'(r_v);
                w_req.b = MUL_B_W'(r_v);
            end
            S_CUBE_CU: begin
                w_req.a = w_prod[MUL_A_W-1:0];
                w_req.b = MUL_B_W'(r_v);
            end
            S_CUBE_SCALE: begin
                w_req.a = w_cube_off;
                w_req.b = MUL_B_W'(ADC_MAX);
            end
            S_PWM_START: begin
                w_req.a = MUL_A_W'(w_x_off);
                w_req.b = MUL_B_W'(PWM_TOP);
            end
            S_DIV_EST: begin
                w_req.a = MUL_A_W'(w_divd);
                w_req.b = MUL_B_W'(w_dc.recip);
            end
            S_DIV_BACK: begin
                w_req.a = MUL_A_W'(w_est);
                w_req.b = w_dc.divisor;
            end
            default: begin
                w_req = '0;
            end
        endcase
    end

    // Sequencer: state, working registers and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= RET_THR;
            r_kind      <= DIV_BY_FIVE;
            r_use_p     <= 1'b0;
            r_ch        <= '0;
            r_out_valid <= 1'b0;
            r_smooth    <= '0;
        end else begin
            // A new result is loaded when the output is empty or being read.
            if (r_state == S_OUT && (!r_out_valid || o_pwm.ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_pwm.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_raw[0] <= i_stick.raw_throttle;
                        r_raw[1] <= i_stick.raw_yaw;
                        r_raw[2] <= i_stick.raw_pitch;
                        r_raw[3] <= i_stick.raw_roll;
                        r_div_a  <= DIVD_W'({r_smooth, 2'b00}) + DIVD_W'(i_stick.raw_throttle);
                        r_use_p  <= 1'b0;
                        r_kind   <= DIV_BY_FIVE;
                        r_ret    <= RET_THR;
                        r_ch     <= '0;
                        r_state  <= S_DIV_EST;
                    end
                end
                S_DIV_EST: begin
                    r_div_a <= w_divd;
                    r_state <= S_DIV_BACK;
                end
                S_DIV_BACK: begin
                    r_q     <= w_est;
                    r_state <= S_DIV_FIX;
                end
                S_DIV_FIX: begin
                    unique case (r_ret)
                        RET_THR: begin
                            r_smooth <= w_q_fix[RAW_W-1:0];
                            r_x      <= w_q_fix[RAW_W-1:0];
                            r_state  <= S_PWM_START;
                        end
                        RET_V: begin
                            r_v     <= w_v_next[7:0];
                            r_state <= S_CUBE_SQ;
                        end
                        RET_CURVE: begin
                            r_x     <= w_q_fix[RAW_W-1:0];
                            r_state <= S_PWM_START;
                        end
                        RET_PWM: begin
                            r_pwm[r_ch] <= w_pwm_clamp;
                            if (w_last) begin
                                r_state <= S_OUT;
                            end else begin
                                r_ch    <= r_ch + 1'b1;
                                r_state <= S_CH_START;
                            end
                        end
                        default: begin
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                S_CH_START: begin
                    if (w_expo) begin
                        r_use_p <= 1'b1;
                        r_kind  <= DIV_BY_ADC;
                        r_ret   <= RET_V;
                        r_state <= S_DIV_EST;
                    end else begin
                        r_x     <= r_raw[r_ch];
                        r_state <= S_PWM_START;
                    end
                end
                S_CUBE_SQ: begin
                    r_state <= S_CUBE_CU;
                end
                S_CUBE_CU: begin
                    r_state <= S_CUBE_SCALE;
                end
                S_CUBE_SCALE: begin
                    r_use_p <= 1'b1;
                    r_kind  <= DIV_BY_CUBE;
                    r_ret   <= RET_CURVE;
                    r_state <= S_DIV_EST;
                end
                S_PWM_START: begin
                    // A stick below its range maps to a non-positive value: zero.
                    if (r_x < w_lo) begin
                        r_pwm[r_ch] <= '0;
                        if (w_last) begin
                            r_state <= S_OUT;
                        end else begin
                            r_ch    <= r_ch + 1'b1;
                            r_state <= S_CH_START;
                        end
                    end else begin
                        r_use_p <= 1'b1;
                        r_kind  <= chan_span(r_ch);
                        r_ret   <= RET_PWM;
                        r_state <= S_DIV_EST;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || o_pwm.ready) begin
                        r_out   <= r_pwm;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_pwm.valid        = r_out_valid;
    assign o_pwm.throttle_pwm = r_out[0];
    assign o_pwm.yaw_pwm      = r_out[1];
    assign o_pwm.pitch_pwm    = r_out[2];
    assign o_pwm.roll_pwm     = r_out[3];

`ifndef NO_ASSERTIONS
    // The quotient estimate never loses significant bits.
    a_est_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV_BACK) |-> (w_shifted[PROD_W-1:QUO_W] == '0))
        else $error("quotient estimate overflows");

    // One correction step suffices: the remainder stays below twice the divisor.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV_FIX) |-> (w_rem < (32'(w_dc.divisor) << 1)))
        else $error("division remainder out of range");

    // After a word is taken the sequencer is busy.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !i_stick.ready)
        else $error("ready right after accept");

    // A finished result waits while the previous one is still unread.
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_valid && !o_pwm.ready) |=> (r_state == S_OUT))
        else $error("result overwrote an unread word");
`endif

endmodule

[tb/scpc_pwm_checker.sv]
// Checker for the stick-to-PWM conditioner: predicts every PWM word and compares it.
`timescale 1ns / 100ps
module scpc_pwm_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    scpc_stick_if                         i_stick,
    scpc_pwm_if                           i_pwm,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [scpc_pkg::APB_AW-1:0]   i_paddr,
    input  logic [scpc_pkg::APB_DW-1:0]   i_pwdata,
    input  logic [scpc_pkg::APB_DW-1:0]   i_prdata,
    input  logic                          i_pready,
    output int                            o_mismatches,
    output int                            o_outstanding
);
    import scpc_pkg::*;

    localparam longint STICK_MAX  = 1023;
    localparam longint DUTY_MAX   = 255;
    localparam longint CURVE_HALF = 100;
    localparam longint CUBE_HALF  = 1_000_000;
    localparam longint THR_BOT    = 1;
    localparam longint THR_TOP    = 1020;
    localparam longint YAW_BOT    = 4;
    localparam longint YAW_TOP    = 1018;
    localparam longint PIT_BOT    = 1;
    localparam longint PIT_TOP    = 1020;
    localparam longint ROL_BOT    = 4;
    localparam longint ROL_TOP    = 1018;
    localparam int     REPORT_LIMIT = 10;
    localparam logic [APB_AW-1:0] EXPO_ADDR = {CFG_EXPO_IDX, 2'b00};

    typedef struct packed {
        logic [PWM_W-1:0] thr;
        logic [PWM_W-1:0] yaw;
        logic [PWM_W-1:0] pit;
        logic [PWM_W-1:0] rol;
    } t_duty_word;

    bit               expo_on = 1'b1;
    logic [RAW_W-1:0] smoothed_thr = '0;
    t_duty_word       duty_q[$];
    int               mismatch_count = 0;

    // Integer rescale; signed division truncates toward zero.
    function automatic longint rescale(input longint x, input longint in_lo,
                                       input longint in_hi, input longint out_lo,
                                       input longint out_hi);
        return (x - in_lo) * (out_hi - out_lo) / (in_hi - in_lo) + out_lo;
    endfunction

    function automatic longint bend(input logic [RAW_W-1:0] raw);
        longint v;
        if (!expo_on) begin
            return longint'(raw);
        end
        v = rescale(longint'(raw), 0, STICK_MAX, -CURVE_HALF, CURVE_HALF);
        return rescale(v * v * v, -CUBE_HALF, CUBE_HALF, 0, STICK_MAX);
    endfunction

    function automatic logic [PWM_W-1:0] to_duty(input longint x, input longint lo,
                                                  input longint hi);
        longint p;
        p = rescale(x, lo, hi, 0, DUTY_MAX);
        if (p < 0) begin
            p = 0;
        end
        if (p > DUTY_MAX) begin
            p = DUTY_MAX;
        end
        return p[PWM_W-1:0];
    endfunction

    // Advances the throttle filter, then forms the word the block must deliver.
    function automatic t_duty_word predict_duty(input logic [RAW_W-1:0] thr,
                                                input logic [RAW_W-1:0] yaw,
                                                input logic [RAW_W-1:0] pit,
                                                input logic [RAW_W-1:0] rol);
        t_duty_word w;
        smoothed_thr = RAW_W'((4 * int'(smoothed_thr) + int'(thr)) / 5);
        w.thr = to_duty(longint'(smoothed_thr), THR_BOT, THR_TOP);
        w.yaw = to_duty(bend(yaw), YAW_BOT, YAW_TOP);
        w.pit = to_duty(bend(pit), PIT_BOT, PIT_TOP);
        w.rol = to_duty(bend(rol), ROL_BOT, ROL_TOP);
        return w;
    endfunction

    task automatic flag_error(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("[%0t] pwm checker: %s", $realtime, what);
        end
    endtask

    always @(posedge i_clk) begin
        t_duty_word got;
        t_duty_word want;
        if (!i_rst_n) begin
            expo_on = 1'b1;
            smoothed_thr = '0;
            duty_q.delete();
        end else begin
            if (i_psel && i_penable && i_pready && i_paddr == EXPO_ADDR) begin
                if (i_pwrite) begin
                    expo_on = i_pwdata[0];
                end else if (i_prdata !== APB_DW'(expo_on)) begin
                    flag_error($sformatf("expo readback expected %0h got %0h",
                                         expo_on, i_prdata));
                end
            end
            if (i_stick.valid && i_stick.ready) begin
                duty_q.push_back(predict_duty(i_stick.raw_throttle, i_stick.raw_yaw,
                                              i_stick.raw_pitch, i_stick.raw_roll));
            end
            if (i_pwm.valid && i_pwm.ready) begin
                got = '{i_pwm.throttle_pwm, i_pwm.yaw_pwm, i_pwm.pitch_pwm, i_pwm.roll_pwm};
                if (duty_q.size() == 0) begin
                    flag_error($sformatf("unexpected word thr %0d yaw %0d pit %0d rol %0d",
                                         got.thr, got.yaw, got.pit, got.rol));
                end else begin
                    want = duty_q.pop_front();
                    if (got.thr !== want.thr || got.yaw !== want.yaw ||
                        got.pit !== want.pit || got.rol !== want.rol) begin
                        flag_error($sformatf({"expected thr %0d yaw %0d pit %0d rol %0d, ",
                                              "got thr %0d yaw %0d pit %0d rol %0d"},
                                             want.thr, want.yaw, want.pit, want.rol,
                                             got.thr, got.yaw, got.pit, got.rol));
                    end
                end
            end
        end
        o_mismatches  <= mismatch_count;
        o_outstanding <= duty_q.size();
    end

endmodule

[tb/tb_stick_to_pwm_conditioner.sv]
// Testbench top of the stick-to-PWM conditioner: stimulus, flow control and verdict.
`timescale 1ns / 100ps
module tb_stick_to_pwm_conditioner;
    import scpc_pkg::*;

    // The clock runs at 8 ns. The watchdog is set far beyond the slowest legal run,
    // which spans roughly 1800 words.
    localparam int HALF_PERIOD_NS = 4;
    localparam int WATCHDOG_NS    = 10_000_000;
    localparam int PHASE_WORDS    = 350;
    localparam int NUM_PHASES     = 5;
    localparam int HOLD_CYCLES    = 600;
    localparam int DRAIN_CYCLES   = 64;
    localparam int DRAIN_LIMIT    = 20000;

    // The expo bit is register 0; index 1 lies past the register list and must be ignored.
    localparam logic [APB_AW-3:0] SPARE_IDX  = (APB_AW-2)'(1);
    localparam logic [APB_AW-1:0] EXPO_ADDR  = {CFG_EXPO_IDX, 2'b00};
    localparam logic [APB_AW-1:0] SPARE_ADDR = {SPARE_IDX, 2'b00};

    typedef struct packed {
        logic [RAW_W-1:0] thr;
        logic [RAW_W-1:0] yaw;
        logic [RAW_W-1:0] pit;
        logic [RAW_W-1:0] rol;
    } t_stick_word;

    // Receiver behaviors: always ready, coin flip, mostly ready, and a short blockage.
    typedef enum int {
        SINK_OPEN,
        SINK_COIN,
        SINK_MOSTLY,
        SINK_BLOCKED
    } t_sink_mode;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    int                mismatches;
    int                outstanding;

    // Handshake between the stimulus and the receiver for the one long hold-off.
    bit                hold_req = 1'b0;
    bit                hold_done = 1'b0;
    logic [RAW_W-1:0]  last_throttle = '0;

    scpc_stick_if stick_bus ();
    scpc_pwm_if   pwm_bus ();

    stick_to_pwm_conditioner uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_stick (stick_bus),
        .o_pwm   (pwm_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    scpc_pwm_checker checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_stick       (stick_bus),
        .i_pwm         (pwm_bus),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_prdata      (prdata),
        .i_pready      (pready),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always #(HALF_PERIOD_NS) clk = ~clk;

    // Presents one word and returns at the edge where it is taken. Valid stays high so
    // that back-to-back calls form a burst; the caller lowers it when a gap follows.
    task automatic send_sample(input t_stick_word w);
        stick_bus.valid        <= 1'b1;
        stick_bus.raw_throttle <= w.thr;
        stick_bus.raw_yaw      <= w.yaw;
        stick_bus.raw_pitch    <= w.pit;
        stick_bus.raw_roll     <= w.rol;
        last_throttle = w.thr;
        @(posedge clk);
        while (!stick_bus.ready) begin
            @(posedge clk);
        end
    endtask

    // Both APB tasks finish by returning psel and penable to idle before they return, so that
    // consecutive transfers never drive psel twice within the same time step.
    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // The checker compares the returned data against its own copy of the register.
    task automatic apb_read(input logic [APB_AW-1:0] addr);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // The upper data bits are random; only bit 0 may take effect.
    task automatic set_expo(input bit on);
        logic [APB_DW-1:0] data;
        data    = $urandom();
        data[0] = on;
        apb_write(EXPO_ADDR, data);
        apb_read(EXPO_ADDR);
    endtask

    // Waits until every predicted word has come out, then lets the block settle.
    task automatic wait_drained();
        stick_bus.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Stick values lean toward the ends of the range, where clamping happens, and
    // toward the center, where the cubic curve is flat.
    function automatic logic [RAW_W-1:0] random_raw();
        case ($urandom_range(0, 7))
            0:       return RAW_W'($urandom_range(0, 6));
            1:       return RAW_W'($urandom_range(1015, 1023));
            2:       return RAW_W'($urandom_range(500, 523));
            default: return RAW_W'($urandom_range(0, 1023));
        endcase
    endfunction

    // Random words in bursts of random length. Throttle often repeats so that the
    // filter gets to settle instead of jumping around.
    task automatic run_random(input int unsigned count);
        int unsigned n;
        int unsigned burst;
        int unsigned gap;
        t_stick_word w;
        burst = 0;
        for (n = 0; n < count; n++) begin
            if (burst == 0) begin
                burst = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                    : $urandom_range(1, 16);
            end
            w.thr = ($urandom_range(0, 3) == 0) ? last_throttle : random_raw();
            w.yaw = random_raw();
            w.pit = random_raw();
            w.rol = random_raw();
            send_sample(w);
            burst--;
            if (burst == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                  : $urandom_range(1, 10);
                stick_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Receiver. It mixes open stretches with random stalls, and once, on request,
    // holds ready low long enough that the output register fills and the input stalls.
    initial begin
        t_sink_mode  mode;
        int unsigned len;
        int unsigned k;
        pwm_bus.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) begin
            @(posedge clk);
        end
        forever begin
            if (hold_req && !hold_done) begin
                pwm_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            mode = t_sink_mode'($urandom_range(0, 3));
            len  = (mode == SINK_BLOCKED) ? $urandom_range(2, 8) : $urandom_range(1, 60);
            for (k = 1; k <= len; k++) begin
                case (mode)
                    SINK_OPEN:   pwm_bus.ready <= 1'b1;
                    SINK_COIN:   pwm_bus.ready <= 1'($urandom_range(0, 1));
                    SINK_MOSTLY: pwm_bus.ready <= ($urandom_range(0, 3) != 0);
                    default:     pwm_bus.ready <= (k == len);
                endcase
                @(posedge clk);
            end
        end
    end

    // Main stimulus and verdict.
    initial begin
        int unsigned phase;
        int unsigned drain;
        bit          expo_val;
        rst_n                  <= 1'b0;
        stick_bus.valid        <= 1'b0;
        stick_bus.raw_throttle <= '0;
        stick_bus.raw_yaw      <= '0;
        stick_bus.raw_pitch    <= '0;
        stick_bus.raw_roll     <= '0;
        psel                   <= 1'b0;
        penable                <= 1'b0;
        pwrite                 <= 1'b0;
        paddr                  <= '0;
        pwdata                 <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The expo bit must read back as set out of reset.
        apb_read(EXPO_ADDR);

        // Directed words with the curve on: all-zero and all-ones, the edges of each
        // stick range and just outside them, the flat center of the curve, and a
        // throttle held high so the filter climbs over several words.
        send_sample('{10'd0,    10'd0,    10'd0,    10'd0});
        send_sample('{10'd1023, 10'd1023, 10'd1023, 10'd1023});
        send_sample('{10'd1023, 10'd1,    10'd1,    10'd1});
        send_sample('{10'd1023, 10'd4,    10'd4,    10'd4});
        send_sample('{10'd1023, 10'd3,    10'd0,    10'd3});
        send_sample('{10'd1023, 10'd1018, 10'd1020, 10'd1018});
        send_sample('{10'd1023, 10'd1019, 10'd1021, 10'd1019});
        send_sample('{10'd1,    10'd511,  10'd511,  10'd512});
        send_sample('{10'd1020, 10'd512,  10'd512,  10'd511});
        send_sample('{10'd0,    10'd5,    10'd2,    10'd1017});
        send_sample('{10'd682,  10'd341,  10'd682,  10'd341});
        send_sample('{10'd341,  10'd682,  10'd341,  10'd682});
        wait_drained();

        // The same kind of words with a linear response.
        set_expo(1'b0);
        send_sample('{10'd1023, 10'd0,    10'd1023, 10'd3});
        send_sample('{10'd1023, 10'd4,    10'd1,    10'd1018});
        send_sample('{10'd2,    10'd1019, 10'd1020, 10'd5});
        send_sample('{10'd0,    10'd1023, 10'd0,    10'd1017});
        send_sample('{10'd512,  10'd511,  10'd512,  10'd511});
        send_sample('{10'd1021, 10'd682,  10'd341,  10'd682});
        wait_drained();

        // A write past the register list must leave the expo bit alone.
        apb_write(SPARE_ADDR, '1);
        apb_read(EXPO_ADDR);
        send_sample('{10'd300,  10'd100,  10'd900,  10'd200});
        send_sample('{10'd700,  10'd800,  10'd150,  10'd950});
        wait_drained();

        // Random phases, each under its own expo setting. Both extremes come first,
        // and the long receiver hold-off falls into the first phase.
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase == 0) begin
                expo_val = 1'b1;
            end else if (phase == 1) begin
                expo_val = 1'b0;
            end else begin
                expo_val = 1'($urandom_range(0, 1));
            end
            set_expo(expo_val);
            if (phase == 0) begin
                hold_req = 1'b1;
            end
            run_random(PHASE_WORDS);
            wait_drained();
        end

        // Final drain with a bound; anything still expected afterwards is a failure.
        drain = 0;
        while (outstanding != 0 && drain < DRAIN_LIMIT) begin
            @(posedge clk);
            drain++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("tb_stick_to_pwm_conditioner: clean");
        end else begin
            $display("tb_stick_to_pwm_conditioner: errors");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #(WATCHDOG_NS);
        $display("tb_stick_to_pwm_conditioner: errors");
        $finish;
    end

endmodule
